// ===== design/lssa_pkg.sv =====
// ----------------------------------------------------------------------------
// lssa_pkg
// Shared widths and types of the linear-scan slot allocator.
// ----------------------------------------------------------------------------
package lssa_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned POS_IN_W  = 16;
  localparam int unsigned REG_OUT_W = 3;

  typedef struct packed {
    logic clear;
    logic write;
  } lssa_upd_t;

  typedef struct packed {
    logic [REG_OUT_W-1:0] assigned_reg;
    logic                 spill_valid;
    logic [ID_W-1:0]      spilled_reg_id;
  } lssa_res_t;

endpackage

// ===== design/lssa_slots.sv =====
// ----------------------------------------------------------------------------
// lssa_slots
// Slot file: busy bits, owners and last-use positions of the allocatable
// registers, with a bulk clear and one write port.
// ----------------------------------------------------------------------------
module lssa_slots
  import lssa_pkg::*;
#(
  parameter int unsigned NUM_REGS = 7,
  parameter int unsigned POS_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lssa_upd_t                   upd_i,
  input  logic [$clog2(NUM_REGS)-1:0] wr_idx_i,
  input  logic [ID_W-1:0]             wr_owner_i,
  input  logic [POS_BITS-1:0]         wr_end_i,
  output logic [NUM_REGS-2:0]         busy_o,
  output logic [ID_W-1:0]             owner_o [NUM_REGS-1],
  output logic [POS_BITS-1:0]         end_o   [NUM_REGS-1]
);

  localparam int unsigned NSLOTS = NUM_REGS - 1;

  logic [NSLOTS-1:0]   busy_q, busy_d;
  logic [ID_W-1:0]     owner_q [NSLOTS];
  logic [POS_BITS-1:0] end_q   [NSLOTS];

  always_comb begin
    busy_d = busy_q;
    if (upd_i.clear) begin
      busy_d = '0;
    end
    if (upd_i.write) begin
      busy_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.write) begin
      owner_q[wr_idx_i] <= wr_owner_i;
      end_q[wr_idx_i]   <= wr_end_i;
    end
  end

  assign busy_o  = busy_q;
  assign owner_o = owner_q;
  assign end_o   = end_q;

endmodule

// ===== design/lssa_decide.sv =====
// ----------------------------------------------------------------------------
// lssa_decide
// Allocation decision for one interval: lowest free slot, otherwise the
// interval with the furthest last use is spilled.
// ----------------------------------------------------------------------------
module lssa_decide
  import lssa_pkg::*;
#(
  parameter int unsigned NUM_REGS = 7,
  parameter int unsigned POS_BITS = 16
) (
  input  logic                        fire_i,
  input  logic                        new_function_i,
  input  logic [ID_W-1:0]             reg_id_i,
  input  logic [POS_BITS-1:0]         def_pos_i,
  input  logic [POS_BITS-1:0]         last_use_pos_i,
  input  logic [NUM_REGS-2:0]         busy_i,
  input  logic [ID_W-1:0]             owner_i [NUM_REGS-1],
  input  logic [POS_BITS-1:0]         end_i   [NUM_REGS-1],
  output lssa_upd_t                   upd_o,
  output logic [$clog2(NUM_REGS)-1:0] wr_idx_o,
  output lssa_res_t                   res_o
);

  localparam int unsigned NSLOTS = NUM_REGS - 1;
  localparam int unsigned IW     = $clog2(NUM_REGS);

  logic [NSLOTS-1:0]   busy_eff;
  logic [NSLOTS-1:0]   free;
  logic                found;
  logic [IW-1:0]       pick;
  logic [IW-1:0]       best;
  logic [POS_BITS-1:0] best_end;
  logic                self_spill;

  assign busy_eff = new_function_i ? '0 : busy_i;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      free[i] = !busy_eff[i] || (end_i[i] <= def_pos_i);
      if (free[i]) begin
        found = 1'b1;
        pick  = IW'(i);
      end
    end
  end

  always_comb begin
    best     = '0;
    best_end = end_i[0];
    for (int i = 1; i < NSLOTS; i++) begin
      if (best_end < end_i[i]) begin
        best     = IW'(i);
        best_end = end_i[i];
      end
    end
  end

  assign self_spill = !found && (best_end < last_use_pos_i);

  always_comb begin
    upd_o.clear = fire_i && new_function_i;
    upd_o.write = fire_i && !self_spill;
    wr_idx_o    = found ? pick : best;
    if (found) begin
      res_o.assigned_reg   = REG_OUT_W'(pick);
      res_o.spill_valid    = 1'b0;
      res_o.spilled_reg_id = '0;
    end else if (self_spill) begin
      res_o.assigned_reg   = REG_OUT_W'(NUM_REGS - 1);
      res_o.spill_valid    = 1'b1;
      res_o.spilled_reg_id = reg_id_i;
    end else begin
      res_o.assigned_reg   = REG_OUT_W'(best);
      res_o.spill_valid    = 1'b1;
      res_o.spilled_reg_id = owner_i[best];
    end
  end

endmodule

// ===== design/linear_scan_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// linear_scan_slot_allocator
// Linear-scan register allocation over NUM_REGS-1 slots plus one reserved
// spill register.
// ----------------------------------------------------------------------------
// Input channel: one beat per live interval (new_function, reg_id, def_pos,
//   last_use_pos), sent in order of definition, accepted when in_valid_i is
//   high and in_stall_o is low.
// Output channel: one beat per interval (assigned_reg, spill_valid,
//   spilled_reg_id), taken when out_valid_o is high and out_stall_i is low.
// Result path: an accepted beat lands in the input register; its result is
//   then loaded into the result register, which drives out_valid_o.
// Throughput: one interval per cycle while no result is held up by out_stall_i. The slot compares, the lowest-free
//   pick and the furthest-end search all sit combinationally between the input
//   register and the result register, and the slot file is written on the
//   same edge, so the next interval sees the updated slots.
// Reset: all slots empty, both registers empty.
// Stall: while out_stall_i holds a waiting result, the input register still
//   fills once; beyond that in_stall_o is raised until the result is taken.
// ----------------------------------------------------------------------------
module linear_scan_slot_allocator
  import lssa_pkg::*;
#(
  parameter int unsigned NUM_REGS = 7,
  parameter int unsigned POS_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 new_function_i,
  input  logic [ID_W-1:0]      reg_id_i,
  input  logic [POS_IN_W-1:0]  def_pos_i,
  input  logic [POS_IN_W-1:0]  last_use_pos_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [REG_OUT_W-1:0] assigned_reg_o,
  output logic                 spill_valid_o,
  output logic [ID_W-1:0]      spilled_reg_id_o
);

  localparam int unsigned IW = $clog2(NUM_REGS);

  logic                in_valid_q;
  logic                nf_q;
  logic [ID_W-1:0]     id_q;
  logic [POS_BITS-1:0] def_q;
  logic [POS_BITS-1:0] last_q;

  logic      out_valid_q;
  lssa_res_t res_q;

  logic out_ready;
  logic fire;
  logic in_take;

  lssa_upd_t           upd;
  logic [IW-1:0]       wr_idx;
  lssa_res_t           res_d;
  logic [NUM_REGS-2:0] busy;
  logic [ID_W-1:0]     owner [NUM_REGS-1];
  logic [POS_BITS-1:0] slot_end [NUM_REGS-1];

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      nf_q   <= new_function_i;
      id_q   <= reg_id_i;
      def_q  <= POS_BITS'(def_pos_i);
      last_q <= POS_BITS'(last_use_pos_i);
    end
  end

  lssa_decide #(
    .NUM_REGS (NUM_REGS),
    .POS_BITS (POS_BITS)
  ) u_decide (
    .fire_i         (fire),
    .new_function_i (nf_q),
    .reg_id_i       (id_q),
    .def_pos_i      (def_q),
    .last_use_pos_i (last_q),
    .busy_i         (busy),
    .owner_i        (owner),
    .end_i          (slot_end),
    .upd_o          (upd),
    .wr_idx_o       (wr_idx),
    .res_o          (res_d)
  );

  lssa_slots #(
    .NUM_REGS (NUM_REGS),
    .POS_BITS (POS_BITS)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .wr_idx_i   (wr_idx),
    .wr_owner_i (id_q),
    .wr_end_i   (last_q),
    .busy_o     (busy),
    .owner_o    (owner),
    .end_o      (slot_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign assigned_reg_o   = res_q.assigned_reg;
  assign spill_valid_o    = res_q.spill_valid;
  assign spilled_reg_id_o = res_q.spilled_reg_id;

endmodule
